// File: hw/rtl/qes_pkg.sv
// Shared types, result codes and pipeline step functions for the quadratic solver.
// No dependencies; imported by quadratic_equation_solver_unit.
package qes_pkg;

  typedef struct packed {
    logic signed [15:0] coef_a;
    logic signed [15:0] coef_b;
    logic signed [15:0] coef_c;
  } coef_t;

  typedef struct packed {
    logic [1:0]         solution_kind;
    logic signed [31:0] root_first;
    logic signed [31:0] root_second;
    logic               overflow;
  } sol_t;

  localparam logic [1:0] KIND_INDET  = 2'd0;
  localparam logic [1:0] KIND_IMPOSS = 2'd1;
  localparam logic [1:0] KIND_LINEAR = 2'd2;
  localparam logic [1:0] KIND_TWO    = 2'd3;

  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 34;
  localparam int NUM_W  = 36;
  localparam int DIV_W  = 16;

  // Per-item control carried alongside the data path.
  typedef struct packed {
    logic [1:0]              kind;
    logic                    dneg;
    logic                    swap;
    logic                    cplx;
    logic signed [NUM_W-1:0] base;
    logic [DIV_W-1:0]        dmag;
  } meta_t;

  typedef struct packed {
    meta_t               meta;
    logic [RAD_W-1:0]    rad;
    logic [REM_W-1:0]    rem;
    logic [ROOT_W-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic             swap;
    logic             neg1;
    logic             neg2;
    logic [DIV_W-1:0] dmag;
    logic [NUM_W-1:0] q1;
    logic [DIV_W-1:0] r1;
    logic [NUM_W-1:0] q2;
    logic [DIV_W-1:0] r2;
  } dv_t;

  // One digit of the restoring square root: two radicand bits in, one root bit out.
  function automatic sq_t sqrt_step(sq_t s);
    sq_t              o;
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    o      = s;
    rem_sh = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial  = {2'b00, s.root, 2'b01};
    if (rem_sh >= trial) begin
      o.rem  = REM_W'(rem_sh - trial);
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = REM_W'(rem_sh);
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    o.rad = s.rad << 2;
    return o;
  endfunction

  // One quotient bit of restoring division on a shared dividend/quotient register.
  function automatic void div_bit(input logic [NUM_W-1:0] q, input logic [DIV_W-1:0] r,
                                  input logic [DIV_W-1:0] d,
                                  output logic [NUM_W-1:0] qo, output logic [DIV_W-1:0] ro);
    logic [DIV_W:0] rs;
    rs = {r, q[NUM_W-1]};
    if (rs >= {1'b0, d}) begin
      ro = DIV_W'(rs - {1'b0, d});
      qo = {q[NUM_W-2:0], 1'b1};
    end else begin
      ro = DIV_W'(rs);
      qo = {q[NUM_W-2:0], 1'b0};
    end
  endfunction

  function automatic dv_t div_step(dv_t s);
    dv_t o;
    o = s;
    div_bit(s.q1, s.r1, s.dmag, o.q1, o.r1);
    div_bit(s.q2, s.r2, s.dmag, o.q2, o.r2);
    return o;
  endfunction

  // Apply sign and saturate a quotient magnitude to Q16.16; bit 32 flags saturation.
  function automatic logic [32:0] clamp_root(logic [NUM_W-1:0] mag, logic neg);
    logic [32:0] o;
    if (neg) begin
      if (mag > NUM_W'(64'h8000_0000)) o = {1'b1, 32'h8000_0000};
      else                             o = {1'b0, 32'(-mag)};
    end else begin
      if (mag > NUM_W'(64'h7FFF_FFFF)) o = {1'b1, 32'h7FFF_FFFF};
      else                             o = {1'b0, mag[31:0]};
    end
    return o;
  endfunction

endpackage

// File: hw/rtl/quadratic_equation_solver_unit.sv
// Quadratic equation classifier and real-root solver, fully pipelined.
// Depends on qes_pkg for payload types, result codes and step functions.

// Takes one coefficient set (a, b, c in signed Q8.8) per cycle unless
// coef_stall is high, and returns one result per set, in order, through a
// product register, a classification register, 32 square-root digit stages,
// a numerator register, 36 restoring-division stages (two dividers side by
// side) and the saturating output register. The whole pipeline advances
// together and holds while a finished result is stalled at the output, so
// coef_stall follows sol_valid and sol_stall.
module quadratic_equation_solver_unit
  import qes_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  coef_valid,
  output logic  coef_stall,
  input  coef_t coef,
  output logic  sol_valid,
  input  logic  sol_stall,
  output sol_t  sol
);

  localparam int SQ_N = ROOT_W;
  localparam int DV_N = NUM_W;

  logic adv;
  assign adv        = !(sol_valid && sol_stall);
  assign coef_stall = !adv;

  // Products
  logic               v1;
  logic signed [15:0] a1, b1, c1;
  logic signed [31:0] bb1, ac1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= coef_valid;
    end
    if (adv) begin
      a1  <= coef.coef_a;
      b1  <= coef.coef_b;
      c1  <= coef.coef_c;
      bb1 <= coef.coef_b * coef.coef_b;
      ac1 <= coef.coef_a * coef.coef_c;
    end
  end

  // Classification and radicand selection
  logic signed [34:0] disc;
  logic [15:0]        amag, bmag;
  logic [30:0]        acmag;
  sq_t                sq_next;

  always_comb begin
    disc  = 35'(bb1) - (35'(ac1) <<< 2);
    amag  = a1[15] ? 16'(-a1) : 16'(a1);
    bmag  = b1[15] ? 16'(-b1) : 16'(b1);
    acmag = ac1[31] ? 31'(-ac1) : 31'(ac1);
    sq_next           = '0;
    sq_next.meta.kind = KIND_IMPOSS;
    sq_next.meta.dmag = 16'd1;
    if (a1 == 0 && b1 == 0) begin
      sq_next.meta.kind = (c1 == 0) ? KIND_INDET : KIND_IMPOSS;
    end else if (a1 == 0) begin
      sq_next.meta.kind = KIND_LINEAR;
      sq_next.meta.base = -(36'(c1) <<< 16);
      sq_next.meta.dmag = bmag;
      sq_next.meta.dneg = b1[15];
    end else if (b1 == 0) begin
      sq_next.meta.dmag = amag;
      if (c1 == 0) begin
        sq_next.meta.kind = KIND_TWO;
      end else if ((a1 > 0) == (c1 > 0)) begin
        sq_next.meta.kind = KIND_IMPOSS;
      end else begin
        // sqrt(|a||c| * 2^32) / |a| equals sqrt(|c|/|a| * 2^32) after flooring
        sq_next.meta.kind = KIND_TWO;
        sq_next.rad       = 64'(acmag) << 32;
      end
    end else begin
      sq_next.meta.cplx = 1'b1;
      sq_next.meta.base = -(36'(b1) <<< 15);
      sq_next.meta.dmag = amag;
      sq_next.meta.dneg = a1[15];
      // with no constant term the formula yields 0 and -b/a; order them as zero first
      sq_next.meta.swap = (c1 == 0) && (b1 > 0);
      if (!disc[34]) begin
        sq_next.meta.kind = KIND_TWO;
        sq_next.rad       = 64'(disc[33:0]) << 16;
      end
    end
  end

  // Square root pipeline
  logic sq_v [0:SQ_N];
  sq_t  sq   [0:SQ_N];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SQ_N; k++) sq_v[k] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= v1;
      for (int k = 0; k < SQ_N; k++) sq_v[k+1] <= sq_v[k];
    end
    if (adv) begin
      sq[0] <= sq_next;
      for (int k = 0; k < SQ_N; k++) sq[k+1] <= sqrt_step(sq[k]);
    end
  end

  // Numerators
  logic signed [NUM_W-1:0] sterm, n1, n2;
  dv_t                     dv_next;

  always_comb begin
    sterm = sq[SQ_N].meta.cplx ? (NUM_W'(sq[SQ_N].root) <<< 7) : NUM_W'(sq[SQ_N].root);
    n1    = sq[SQ_N].meta.base - sterm;
    n2    = sq[SQ_N].meta.base + sterm;
    dv_next      = '0;
    dv_next.kind = sq[SQ_N].meta.kind;
    dv_next.swap = sq[SQ_N].meta.swap;
    dv_next.dmag = sq[SQ_N].meta.dmag;
    dv_next.neg1 = n1[NUM_W-1] ^ sq[SQ_N].meta.dneg;
    dv_next.neg2 = n2[NUM_W-1] ^ sq[SQ_N].meta.dneg;
    dv_next.q1   = n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
    dv_next.q2   = n2[NUM_W-1] ? NUM_W'(-n2) : NUM_W'(n2);
  end

  // Division pipeline
  logic dv_v [0:DV_N];
  dv_t  dv   [0:DV_N];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DV_N; k++) dv_v[k] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sq_v[SQ_N];
      for (int k = 0; k < DV_N; k++) dv_v[k+1] <= dv_v[k];
    end
    if (adv) begin
      dv[0] <= dv_next;
      for (int k = 0; k < DV_N; k++) dv[k+1] <= div_step(dv[k]);
    end
  end

  // Saturate, order and drop roots for kinds without any
  logic [32:0] cl1, cl2;
  logic        has_roots;
  sol_t        sol_next;

  always_comb begin
    cl1       = clamp_root(dv[DV_N].q1, dv[DV_N].neg1);
    cl2       = clamp_root(dv[DV_N].q2, dv[DV_N].neg2);
    has_roots = (dv[DV_N].kind == KIND_LINEAR) || (dv[DV_N].kind == KIND_TWO);
    sol_next               = '0;
    sol_next.solution_kind = dv[DV_N].kind;
    if (has_roots) begin
      sol_next.overflow = cl1[32] | cl2[32];
      if (dv[DV_N].swap) begin
        sol_next.root_first  = cl2[31:0];
        sol_next.root_second = cl1[31:0];
      end else begin
        sol_next.root_first  = cl1[31:0];
        sol_next.root_second = cl2[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sol_valid <= 1'b0;
    end else if (adv) begin
      sol_valid <= dv_v[DV_N];
    end
    if (adv) begin
      sol <= sol_next;
    end
  end

`ifndef SYNTHESIS
  a_no_roots_zero: assert property (@(posedge clk) disable iff (rst)
    sol_valid && (sol.solution_kind == KIND_INDET || sol.solution_kind == KIND_IMPOSS)
    |-> sol.root_first == 0 && sol.root_second == 0 && !sol.overflow)
    else $error("roots or overflow set on a result without roots");

  a_linear_equal: assert property (@(posedge clk) disable iff (rst)
    sol_valid && sol.solution_kind == KIND_LINEAR |-> sol.root_first == sol.root_second)
    else $error("linear result carries two different roots");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    sol_valid && sol_stall |=> sol_valid && $stable(sol) && $stable(dv_v[DV_N]))
    else $error("pipeline moved while the result was stalled");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for quadratic_equation_solver_unit: directed table plus random
// coefficient sets, checked against a local root predictor. Depends on qes_pkg.
module tb_top;
  import qes_pkg::*;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  coef_valid = 1'b0;
  logic  coef_stall;
  coef_t coef = '0;
  logic  sol_valid;
  logic  sol_stall = 1'b0;
  sol_t  sol;

  sol_t  pending_sols[$];
  int    mismatches = 0;
  bit    stim_done = 1'b0;
  bit    long_hold = 1'b0;

  typedef struct {
    logic signed [15:0] a, b, c;
    bit                 known;
    sol_t               sol;
  } row_t;

  always #6 clk = ~clk;

  quadratic_equation_solver_unit DUT (
    .clk(clk), .rst(rst), .coef_valid(coef_valid), .coef_stall(coef_stall),
    .coef(coef), .sol_valid(sol_valid), .sol_stall(sol_stall), .sol(sol)
  );

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint saturate_q(longint v, ref logic ov);
    if (v > 64'sd2147483647) begin
      ov = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ov = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic sol_t solve_roots(coef_t q);
    longint a, b, c, r1, r2, disc, s, mb, r;
    logic [63:0] ua, uc;
    logic ov;
    sol_t o;
    a = q.coef_a; b = q.coef_b; c = q.coef_c;
    r1 = 0; r2 = 0; ov = 1'b0;
    o.solution_kind = KIND_INDET;
    if (a == 0 && b == 0) begin
      o.solution_kind = (c == 0) ? KIND_INDET : KIND_IMPOSS;
    end else if (a == 0) begin
      o.solution_kind = KIND_LINEAR;
      r1 = saturate_q((-c * 65536) / b, ov);
      r2 = r1;
    end else if (b == 0) begin
      if (c == 0) begin
        o.solution_kind = KIND_TWO;
      end else if ((a > 0) == (c > 0)) begin
        o.solution_kind = KIND_IMPOSS;
      end else begin
        ua = (a < 0) ? -a : a;
        uc = (c < 0) ? -c : c;
        r  = int_sqrt((uc << 32) / ua);
        o.solution_kind = KIND_TWO;
        r1 = -r;
        r2 = r;
      end
    end else if (c == 0) begin
      o.solution_kind = KIND_TWO;
      r2 = saturate_q((-b * 65536) / a, ov);
    end else begin
      disc = b * b - 4 * a * c;
      if (disc < 0) begin
        o.solution_kind = KIND_IMPOSS;
      end else begin
        s  = int_sqrt(disc << 16);
        mb = -b * 256;
        o.solution_kind = KIND_TWO;
        r1 = saturate_q(((mb - s) * 128) / a, ov);
        r2 = saturate_q(((mb + s) * 128) / a, ov);
      end
    end
    o.root_first  = r1[31:0];
    o.root_second = r2[31:0];
    o.overflow    = ov;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $time);
    mismatches++;
  endtask

  function automatic sol_t mk_sol(logic [1:0] k, int r1, int r2, logic ov);
    sol_t o;
    o.solution_kind = k;
    o.root_first    = r1;
    o.root_second   = r2;
    o.overflow      = ov;
    return o;
  endfunction

  function automatic row_t mk_row(int a, int b, int c, bit known, sol_t s);
    row_t r;
    r.a = 16'(a); r.b = 16'(b); r.c = 16'(c); r.known = known; r.sol = s;
    return r;
  endfunction

  // Send one request; hold valid and payload until accepted.
  task automatic send_request(coef_t q, sol_t want);
    coef_valid <= 1'b1;
    coef       <= q;
    @(posedge clk);
    while (coef_stall) @(posedge clk);
    pending_sols.push_back(want);
  endtask

  task automatic idle_sender();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      coef_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return 16'(int'($urandom_range(0, 512)) - 256);
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    row_t  dir_rows[$];
    coef_t q;
    sol_t  want;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dir_rows.push_back(mk_row(0, 0, 0, 1, mk_sol(KIND_INDET, 0, 0, 0)));
    dir_rows.push_back(mk_row(0, 0, 5, 1, mk_sol(KIND_IMPOSS, 0, 0, 0)));
    dir_rows.push_back(mk_row(0, 0, -32768, 1, mk_sol(KIND_IMPOSS, 0, 0, 0)));
    dir_rows.push_back(mk_row(0, 256, -256, 1, mk_sol(KIND_LINEAR, 65536, 65536, 0)));
    dir_rows.push_back(mk_row(0, 1, -32768, 1,
                              mk_sol(KIND_LINEAR, 32'h7FFFFFFF, 32'h7FFFFFFF, 1)));
    dir_rows.push_back(mk_row(0, 1, 32767, 0, '0));
    dir_rows.push_back(mk_row(0, -32768, 32767, 0, '0));
    dir_rows.push_back(mk_row(256, 0, -1024, 1, mk_sol(KIND_TWO, -131072, 131072, 0)));
    dir_rows.push_back(mk_row(1, 0, -32768, 0, '0));
    dir_rows.push_back(mk_row(-32768, 0, 32767, 0, '0));
    dir_rows.push_back(mk_row(256, 0, 256, 1, mk_sol(KIND_IMPOSS, 0, 0, 0)));
    dir_rows.push_back(mk_row(-5, 0, -7, 1, mk_sol(KIND_IMPOSS, 0, 0, 0)));
    dir_rows.push_back(mk_row(77, 0, 0, 1, mk_sol(KIND_TWO, 0, 0, 0)));
    dir_rows.push_back(mk_row(256, -512, 0, 1, mk_sol(KIND_TWO, 0, 131072, 0)));
    dir_rows.push_back(mk_row(1, -32768, 0, 0, '0));
    dir_rows.push_back(mk_row(-32768, -32768, 0, 0, '0));
    dir_rows.push_back(mk_row(256, 256, 256, 1, mk_sol(KIND_IMPOSS, 0, 0, 0)));
    dir_rows.push_back(mk_row(256, -768, 512, 0, '0));
    dir_rows.push_back(mk_row(256, 512, 256, 0, '0));
    dir_rows.push_back(mk_row(1, -32768, 1, 0, '0));
    dir_rows.push_back(mk_row(-32768, 32767, 32767, 0, '0));
    dir_rows.push_back(mk_row(32767, -32768, -32768, 0, '0));
    dir_rows.push_back(mk_row(-1, 1, 32767, 0, '0));

    foreach (dir_rows[i]) begin
      q.coef_a = dir_rows[i].a;
      q.coef_b = dir_rows[i].b;
      q.coef_c = dir_rows[i].c;
      want = dir_rows[i].known ? dir_rows[i].sol : solve_roots(q);
      send_request(q, want);
      idle_sender();
    end

    for (int n = 0; n < 950; n++) begin
      q.coef_a = rand_coef();
      q.coef_b = rand_coef();
      q.coef_c = rand_coef();
      // Keep a share of complete equations with a real discriminant.
      if ($urandom_range(0, 3) == 0 && q.coef_a != 0 && q.coef_c != 0 &&
          q.coef_b != 0 && ((q.coef_a > 0) == (q.coef_c > 0)))
        q.coef_c = -q.coef_c;
      send_request(q, solve_roots(q));
      if (n == 400) long_hold = 1'b1;
      if (n < 100 || n > 500) idle_sender();
    end
    coef_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stall per request, plus one long hold-off.
  initial begin
    int wait_cycles;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        sol_stall <= 1'b1;
        repeat (200) @(posedge clk);
        sol_stall <= 1'b0;
      end else if (sol_valid && !sol_stall) begin
        wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
        if (wait_cycles > 0) begin
          sol_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
          sol_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    sol_t want;
    if (!rst && sol_valid && !sol_stall) begin
      if (pending_sols.size() == 0) begin
        report_mismatch("unexpected solution", sol.solution_kind, -1);
      end else begin
        want = pending_sols.pop_front();
        if (sol.solution_kind !== want.solution_kind)
          report_mismatch("solution_kind", sol.solution_kind, want.solution_kind);
        if (sol.root_first !== want.root_first)
          report_mismatch("root_first", sol.root_first, want.root_first);
        if (sol.root_second !== want.root_second)
          report_mismatch("root_second", sol.root_second, want.root_second);
        if (sol.overflow !== want.overflow)
          report_mismatch("overflow", sol.overflow, want.overflow);
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_sols.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
